### hw/rtl/rme_pkg.sv
// rme_pkg: shared types and constants for the rsa modular exponentiation block
// no dependencies
package rme_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int EXP_WIDTH     = 32;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MODULUS  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PUB_EXP  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PRIV_EXP = 2'd2;

   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_STEP,
      ST_MUL_ACC,
      ST_MUL_SQ,
      ST_FINISH
   } seq_state_type;

   // start a multiplication; short_op scans only the residue bits of op_b
   typedef struct packed {
      logic start;
      logic short_op;
   } mul_ctl_type;

endpackage

### hw/rtl/rme_if.sv
// rme_if: valid/ready channel interfaces for request and response beats
// depends on rme_pkg for the data width
interface rme_req_if import rme_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [DATA_WIDTH-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface rme_rsp_if import rme_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] result_value;

   modport source (output valid, output result_value, input ready);
   modport sink   (input valid, input result_value, output ready);
endinterface

### hw/rtl/rme_mulmod.sv
// rme_mulmod: bit-serial interleaved modular multiplier, one multiplier bit a cycle
// depends on rme_pkg
module rme_mulmod import rme_pkg::*; #(
   parameter int MOD_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mul_ctl_type           ctl,
   input  logic [MOD_WIDTH-1:0]  op_a,
   input  logic [DATA_WIDTH-1:0] op_b,
   input  logic [MOD_WIDTH-1:0]  modulus,
   output logic                  done,
   output logic [MOD_WIDTH-1:0]  product
);

   localparam int SHIFT     = DATA_WIDTH - MOD_WIDTH;
   localparam int CNT_WIDTH = $clog2(DATA_WIDTH + 1);
   localparam int SUM_WIDTH = MOD_WIDTH + 2;

   logic [MOD_WIDTH-1:0]  a_ff, a_in;
   logic [DATA_WIDTH-1:0] b_ff, b_in;
   logic [MOD_WIDTH-1:0]  r_ff, r_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                  done_ff, done_in;

   logic [SUM_WIDTH-1:0]  sum;
   logic [SUM_WIDTH:0]    diff1, diff2;
   logic [MOD_WIDTH-1:0]  reduced;

   // r < m and a < m, so 2r + a < 3m: at most two subtractions of m
   always_comb begin
      sum   = {1'b0, r_ff, 1'b0}
              + (b_ff[DATA_WIDTH-1] ? SUM_WIDTH'(a_ff) : SUM_WIDTH'(0));
      diff1 = {1'b0, sum} - {2'b00, 1'b0, modulus};
      diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
      if (!diff2[SUM_WIDTH]) begin
         reduced = diff2[MOD_WIDTH-1:0];
      end else if (!diff1[SUM_WIDTH]) begin
         reduced = diff1[MOD_WIDTH-1:0];
      end else begin
         reduced = sum[MOD_WIDTH-1:0];
      end
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      done_in = (cnt_ff == CNT_WIDTH'(1)) && !ctl.start;
      if (ctl.start) begin
         a_in   = op_a;
         b_in   = ctl.short_op ? (op_b << SHIFT) : op_b;
         r_in   = '0;
         cnt_in = ctl.short_op ? CNT_WIDTH'(MOD_WIDTH) : CNT_WIDTH'(DATA_WIDTH);
      end else if (cnt_ff != '0) begin
         b_in   = b_ff << 1;
         r_in   = reduced;
         cnt_in = cnt_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      r_ff <= r_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule

### hw/rtl/rme_seq.sv
// rme_seq: right-to-left square-and-multiply sequencer over the exponent shift register
// depends on rme_pkg; drives rme_mulmod
module rme_seq import rme_pkg::*; #(
   parameter int MOD_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [DATA_WIDTH-1:0] req_value,
   input  logic [MOD_WIDTH-1:0]  modulus,
   input  logic [EXP_WIDTH-1:0]  pub_exp,
   input  logic [EXP_WIDTH-1:0]  priv_exp,
   output mul_ctl_type           mul_ctl,
   output logic [MOD_WIDTH-1:0]  mul_a,
   output logic [DATA_WIDTH-1:0] mul_b,
   input  logic                  mul_done,
   input  logic [MOD_WIDTH-1:0]  mul_product,
   input  logic                  out_free,
   output logic                  out_load,
   output logic [DATA_WIDTH-1:0] out_data
);

   seq_state_type state_ff, state_in;

   logic                 func_ff, func_in;
   logic [EXP_WIDTH-1:0] expo_ff, expo_in;
   logic [MOD_WIDTH-1:0] acc_ff, acc_in;
   logic [MOD_WIDTH-1:0] sq_ff, sq_in;

   logic mod_small;
   logic expo_more;

   assign mod_small = modulus < MOD_WIDTH'(2);
   assign expo_more = expo_ff[EXP_WIDTH-1:1] != '0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = mod_small ? ST_FINISH : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (expo_ff == '0) begin
               state_in = ST_FINISH;
            end else if (expo_ff[0]) begin
               state_in = ST_MUL_ACC;
            end else begin
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_ACC: begin
            if (mul_done) begin
               state_in = expo_more ? ST_MUL_SQ : ST_FINISH;
            end
         end
         ST_MUL_SQ: begin
            if (mul_done) begin
               state_in = ST_STEP;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      func_in   = func_ff;
      expo_in   = expo_ff;
      acc_in    = acc_ff;
      sq_in     = sq_ff;
      req_ready = 1'b0;
      mul_ctl   = '0;
      mul_a     = sq_ff;
      mul_b     = DATA_WIDTH'(acc_ff);
      out_load  = 1'b0;
      out_data  = (func_ff == FUNC_DECRYPT) ? DATA_WIDTH'(acc_ff[7:0])
                                            : DATA_WIDTH'(acc_ff);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // base reduction: 1 * value mod m over all value bits
            mul_a     = MOD_WIDTH'(1);
            mul_b     = req_value;
            if (req_valid) begin
               func_in = req_func;
               expo_in = (req_func == FUNC_DECRYPT) ? priv_exp : pub_exp;
               if (mod_small) begin
                  acc_in = '0;
               end else begin
                  mul_ctl.start = 1'b1;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               sq_in  = mul_product;
               acc_in = MOD_WIDTH'(1);
            end
         end
         ST_STEP: begin
            if (expo_ff != '0) begin
               mul_ctl.start    = 1'b1;
               mul_ctl.short_op = 1'b1;
               if (!expo_ff[0]) begin
                  expo_in = expo_ff >> 1;
                  mul_b   = DATA_WIDTH'(sq_ff);
               end
            end
         end
         ST_MUL_ACC: begin
            mul_b = DATA_WIDTH'(sq_ff);
            if (mul_done) begin
               acc_in  = mul_product;
               expo_in = expo_ff >> 1;
               // skip the final squaring once no exponent bits remain
               if (expo_more) begin
                  mul_ctl.start    = 1'b1;
                  mul_ctl.short_op = 1'b1;
               end
            end
         end
         ST_MUL_SQ: begin
            if (mul_done) begin
               sq_in = mul_product;
            end
         end
         ST_FINISH: begin
            out_load = out_free;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      func_ff <= func_in;
      expo_ff <= expo_in;
      acc_ff  <= acc_in;
      sq_ff   <= sq_in;
   end

endmodule

### hw/rtl/rsa_modexp_cipher_top.sv
// rsa_modexp_cipher_top: one value per beat raised to e or d mod N, bit-serial multiplier.
// decrypt results keep only the low byte of the residue; a modulus below two gives zero
// throughput: one item at a time, set by the serial multiplier taking one bit per cycle
// a new request is taken while the previous response waits in the output register
// synchronous reset clears control and loads the register defaults N=2491, e=3, d=1595
module rsa_modexp_cipher_top import rme_pkg::*; #(
   parameter int MOD_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   rme_req_if.sink                  req_bus,
   rme_rsp_if.source                rsp_bus,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]    csr_wdata
);

   logic [MOD_WIDTH-1:0]  modulus_ff;
   logic [EXP_WIDTH-1:0]  pub_exp_ff;
   logic [EXP_WIDTH-1:0]  priv_exp_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;

   mul_ctl_type           mul_ctl;
   logic [MOD_WIDTH-1:0]  mul_a;
   logic [DATA_WIDTH-1:0] mul_b;
   logic                  mul_done;
   logic [MOD_WIDTH-1:0]  mul_product;
   logic                  out_free;
   logic                  out_load;
   logic [DATA_WIDTH-1:0] out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= MOD_WIDTH'(32'd2491);
         pub_exp_ff  <= EXP_WIDTH'(3);
         priv_exp_ff <= EXP_WIDTH'(1595);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODULUS:  modulus_ff  <= csr_wdata[MOD_WIDTH-1:0];
            CSR_PUB_EXP:  pub_exp_ff  <= csr_wdata;
            CSR_PRIV_EXP: priv_exp_ff <= csr_wdata;
            default: begin
               modulus_ff <= modulus_ff;
            end
         endcase
      end
   end

   rme_seq #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .req_func    (req_bus.func),
      .req_value   (req_bus.value),
      .modulus     (modulus_ff),
      .pub_exp     (pub_exp_ff),
      .priv_exp    (priv_exp_ff),
      .mul_ctl     (mul_ctl),
      .mul_a       (mul_a),
      .mul_b       (mul_b),
      .mul_done    (mul_done),
      .mul_product (mul_product),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_data    (out_data)
   );

   rme_mulmod #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (modulus_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   // output register frees up in the same cycle its beat is taken
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = out_data;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_value = rsp_value_ff;

endmodule

### hw/rtl/rme_checker.sv
// rme_checker: port-level assertions for rsa_modexp_cipher_top, with its bind
// depends on rme_pkg and the top level port list
module rme_checker import rme_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_value
);

   // no response beat is left over from before reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a request beat starts work, so no further request is taken next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // the result never appears in the cycle right after its request
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("response too early");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))
      else $error("stalled response beat changed");

endmodule

bind rsa_modexp_cipher_top rme_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_value (rsp_bus.result_value)
);

### bench/rsa_modexp_cipher_top_tb.sv
// rsa_modexp_cipher_top_tb: self-checking bench for the rsa modular exponentiation block
// depends on rme_pkg, the rme_req_if / rme_rsp_if interfaces and rsa_modexp_cipher_top
// random keys and values are checked against a square-and-multiply predictor
import rme_pkg::*;

class modexp_scoreboard;
   logic [DATA_WIDTH-1:0] modulus_n;
   logic [DATA_WIDTH-1:0] enc_exp;
   logic [DATA_WIDTH-1:0] dec_exp;
   logic [DATA_WIDTH-1:0] mod_mask;
   logic [DATA_WIDTH-1:0] pending_results[$];
   int                    errors;

   function new(int width);
      mod_mask  = DATA_WIDTH'((64'd1 << width) - 64'd1);
      modulus_n = 32'd2491 & mod_mask;
      enc_exp   = 32'd3;
      dec_exp   = 32'd1595;
      errors    = 0;
   endfunction

   function void set_key(logic [DATA_WIDTH-1:0] n, logic [DATA_WIDTH-1:0] e,
                         logic [DATA_WIDTH-1:0] d);
      modulus_n = n & mod_mask;
      enc_exp   = e;
      dec_exp   = d;
   endfunction

   // right-to-left square and multiply, residues stay below 2^32 so 64 bits suffice
   function logic [DATA_WIDTH-1:0] power_residue(logic [DATA_WIDTH-1:0] base,
                                                 logic [DATA_WIDTH-1:0] expo,
                                                 logic [DATA_WIDTH-1:0] m);
      logic [63:0]           acc;
      logic [63:0]           sq;
      logic [DATA_WIDTH-1:0] bits;
      if (m < 2) return '0;
      acc  = 64'd1;
      sq   = 64'(base % m);
      bits = expo;
      while (bits != 0) begin
         if (bits[0]) acc = (acc * sq) % m;
         bits = bits >> 1;
         sq   = (sq * sq) % m;
      end
      return acc[DATA_WIDTH-1:0];
   endfunction

   function void note_request(logic func, logic [DATA_WIDTH-1:0] value);
      logic [DATA_WIDTH-1:0] r;
      if (func == FUNC_ENCRYPT) begin
         r = power_residue(value, enc_exp, modulus_n);
      end else begin
         r = power_residue(value, dec_exp, modulus_n);
         r = {24'd0, r[7:0]};
      end
      pending_results.push_back(r);
   endfunction

   task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
   endtask

   task check_result(logic [DATA_WIDTH-1:0] got);
      logic [DATA_WIDTH-1:0] want;
      if (pending_results.size() == 0) begin
         report($sformatf("response beat 0x%08h with nothing pending", got));
      end else begin
         want = pending_results.pop_front();
         if (got !== want)
            report($sformatf("result_value 0x%08h, expected 0x%08h", got, want));
      end
   endtask
endclass

module rsa_modexp_cipher_top_tb;
   localparam int MOD_WIDTH     = 32;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int TARGET_ITEMS  = 290;
   localparam int SETTLE_CYCLES = 2300;
   localparam int HOLD_CYCLES   = 6000;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [DATA_WIDTH-1:0]    csr_wdata;

   rme_req_if req_bus();
   rme_rsp_if rsp_bus();

   modexp_scoreboard board;
   int cycle_count = 0;
   int items_sent  = 0;
   int beats_back  = 0;
   int req_gap_max = 10;
   int rsp_gap_max = 10;
   bit bench_live  = 1'b0;

   rsa_modexp_cipher_top #(.MOD_WIDTH(MOD_WIDTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rsa_modexp_cipher_top_tb: done, errors");
         $finish;
      end
   end

   task automatic send_request(input logic func, input logic [DATA_WIDTH-1:0] value);
      int gap;
      gap = (req_gap_max > 0) ? $urandom_range(0, req_gap_max) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func  <= func;
      req_bus.value <= value;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      board.note_request(func, value);
      items_sent++;
   endtask

   // only once every pending beat is back, so the block is idle for the writes
   task automatic load_key(input logic [DATA_WIDTH-1:0] n, input logic [DATA_WIDTH-1:0] e,
                           input logic [DATA_WIDTH-1:0] d);
      req_bus.valid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MODULUS;
      csr_wdata <= n;
      @(posedge clock);
      csr_index <= CSR_PUB_EXP;
      csr_wdata <= e;
      @(posedge clock);
      csr_index <= CSR_PRIV_EXP;
      csr_wdata <= d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_key(n, e, d);
   endtask

   function automatic logic [DATA_WIDTH-1:0] pick_exponent();
      int k;
      case ($urandom_range(0, 7))
         0: return '0;
         1: return $urandom;
         default: begin
            k = $urandom_range(1, 12);
            return $urandom_range(1, (1 << k) - 1);
         end
      endcase
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_modulus();
      logic [DATA_WIDTH-1:0] n;
      case ($urandom_range(0, 3))
         0: n = $urandom;
         1: n = {1'b1, 31'($urandom)};
         2: n = $urandom_range(2, 65535);
         default: n = $urandom_range(2, 300);
      endcase
      return (n < 2) ? 32'd2 : n;
   endfunction

   // response side: random stalls, plus two long hold-offs so the block backs up
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      wait (bench_live);
      forever begin
         gap = (rsp_gap_max > 0) ? $urandom_range(0, rsp_gap_max) : 0;
         if (beats_back == 40 || beats_back == 170) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         board.check_result(rsp_bus.result_value);
         beats_back++;
      end
   end

   initial begin
      logic [DATA_WIDTH-1:0] n;
      logic [DATA_WIDTH-1:0] m;
      logic [DATA_WIDTH-1:0] c;
      logic                  f;
      int                    phase_len;
      board = new(MOD_WIDTH);
      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_MODULUS;
      csr_wdata     <= '0;
      req_bus.valid <= 1'b0;
      req_bus.func  <= FUNC_ENCRYPT;
      req_bus.value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      bench_live = 1'b1;

      // reset key: N=2491, e=3, d=1595
      send_request(FUNC_ENCRYPT, 32'd0);
      send_request(FUNC_ENCRYPT, 32'd1);
      send_request(FUNC_ENCRYPT, 32'd255);
      send_request(FUNC_ENCRYPT, 32'd256);
      send_request(FUNC_ENCRYPT, 32'd2491);
      send_request(FUNC_ENCRYPT, 32'hFFFF_FFFF);
      send_request(FUNC_DECRYPT, 32'd0);
      send_request(FUNC_DECRYPT, 32'd2490);
      send_request(FUNC_DECRYPT, 32'hFFFF_FFFF);
      c = board.power_residue(32'd65, board.enc_exp, board.modulus_n);
      send_request(FUNC_ENCRYPT, 32'd65);
      send_request(FUNC_DECRYPT, c);

      // modulus of zero and of one give zero everywhere
      load_key(32'd0, 32'd5, 32'd7);
      send_request(FUNC_ENCRYPT, 32'hFFFF_FFFF);
      send_request(FUNC_DECRYPT, 32'd12345);
      load_key(32'd1, 32'd5, 32'd7);
      send_request(FUNC_ENCRYPT, 32'd7);
      send_request(FUNC_DECRYPT, 32'hFFFF_FFFF);

      // zero exponent gives one, largest exponents and modulus
      load_key(32'd2, 32'd0, 32'hFFFF_FFFF);
      send_request(FUNC_ENCRYPT, 32'd0);
      send_request(FUNC_ENCRYPT, 32'd3);
      send_request(FUNC_DECRYPT, 32'hFFFF_FFFF);
      load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      send_request(FUNC_ENCRYPT, 32'hFFFF_FFFE);
      send_request(FUNC_DECRYPT, 32'h1234_5678);

      while (items_sent < TARGET_ITEMS) begin
         phase_len = $urandom_range(15, 35);
         if ($urandom_range(0, 3) == 0) begin
            // real key pairs: encrypt a byte, then decrypt its ciphertext
            case ($urandom_range(0, 2))
               0: load_key(32'd2491, 32'd3, 32'd1595);
               1: load_key(32'd3233, 32'd17, 32'd2753);
               default: load_key(32'd33, 32'd3, 32'd7);
            endcase
            req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            repeat (phase_len / 2) begin
               m = $urandom_range(0, 255);
               c = board.power_residue(m, board.enc_exp, board.modulus_n);
               send_request(FUNC_ENCRYPT, m);
               send_request(FUNC_DECRYPT, c);
            end
         end else begin
            load_key(pick_modulus(), pick_exponent(), pick_exponent());
            req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            n = board.modulus_n;
            repeat (phase_len) begin
               f = $urandom_range(0, 1);
               case ($urandom_range(0, 3))
                  0: m = $urandom_range(0, 255);
                  1: m = $urandom;
                  2: m = $urandom % n;
                  default: m = n - 1 + $urandom_range(0, 2);
               endcase
               send_request(f, m);
            end
         end
      end

      req_bus.valid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("rsa_modexp_cipher_top_tb: done, clean");
      end else begin
         $display("rsa_modexp_cipher_top_tb: done, errors");
      end
      $finish;
   end
endmodule
